/* src/rv_pkg.sv */
package rv_pkg;

    localparam int LR_W       = 24;  // log return, Q3.20
    localparam int WL_W       = 9;   // window_len register
    localparam int PPY_W      = 11;  // periods_per_year register
    localparam int VOL_W      = 32;  // volatility, Q8.24
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int SUM_W  = 33;              // signed running sum
    localparam int SQ_W   = 56;              // running sum of squares
    localparam int XSQ_W  = 2 * LR_W;        // one squared return
    localparam int PROD_W = 64;              // W*sumsq, sum*sum, difference
    localparam int ACC_W  = PROD_W + PPY_W;  // difference times P
    localparam int NUM_W  = ACC_W + 8;       // times 256
    localparam int DIV_W  = 2 * WL_W;        // W*(W-1)
    localparam int SQR_W  = 2 * VOL_W;       // radicand
    localparam int CNT_W  = 7;

    localparam int WINDOW_MAX_DEF = 256;
    localparam int WL_RESET       = 20;
    localparam int PPY_RESET      = 252;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPY        = 2'd1;

endpackage

/* src/rv_ram.sv */
module rv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rolling_volatility_core.sv */
// Rolling annualized sample standard deviation. Each item is one log return
// (signed Q3.20) and gives exactly one result item: volatility in unsigned
// Q8.24, floor(sqrt(P*256*(W*sumsq - sum^2)/(W*(W-1)))), saturated to all
// ones, with vol_valid high once W returns are held (before that the result
// is zero and vol_valid low). W is window_len clamped to 2..WINDOW_MAX and
// to at most 511; a write of window_len empties the window, a write of
// periods_per_year takes effect on the next item. One item is in work at a
// time. While the window is still filling, an item goes from S_IDLE through
// S_RD and S_UPD straight to S_DONE. With a full window it also goes through
// the shift-add multiply by periods_per_year (11 steps), the bit-serial
// divider by W*(W-1) (83 steps, one quotient bit per cycle) and the
// bit-serial root (32 steps, one root bit per cycle). A saturated result
// skips the root. An output stall holds the block in S_DONE only when the
// output register is still full when the next result is done. A finished
// result sits in an output register, so the next item is taken while it
// waits to be read.
module rolling_volatility_core
    import rv_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [LR_W-1:0]        i_log_return,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VOL_W-1:0]       o_volatility,
    output logic                   o_vol_valid,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW    = $clog2(WINDOW_MAX);
    // window_len is 9 bits, so W never exceeds this even for a deep store
    localparam int WMAX9 = (WINDOW_MAX > 511) ? 511 : WINDOW_MAX;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_UPD   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_SUB   = 4'd4;
    localparam logic [3:0] S_PMUL  = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_SINIT = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]              r_state;
    logic [WL_W-1:0]         r_wl;
    logic [PPY_W-1:0]        r_ppy;

    // window state
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sumsq;
    logic [WL_W-1:0]         r_fill;
    logic [AW-1:0]           r_wpos;

    // per-item work registers
    logic signed [LR_W-1:0]  r_x;
    logic [AW-1:0]           r_pos;
    logic                    r_full;
    logic [XSQ_W-1:0]        r_xsq;
    logic [XSQ_W-1:0]        r_oldsq;
    logic [PROD_W-1:0]       r_a;
    logic [PROD_W-1:0]       r_b;
    logic [ACC_W-1:0]        r_acc;
    logic [PPY_W-1:0]        r_pm;
    logic [DIV_W-1:0]        r_dv;
    logic [NUM_W-1:0]        r_num;
    logic [DIV_W-1:0]        r_rem;
    logic [SQR_W-1:0]        r_q;
    logic                    r_ovf;
    logic [VOL_W-1:0]        r_root;
    logic [VOL_W+1:0]        r_srem;
    logic [CNT_W-1:0]        r_cnt;

    logic [VOL_W-1:0]        r_res;
    logic                    r_resv;
    logic                    r_out_valid;
    logic [VOL_W-1:0]        r_vol;
    logic                    r_volv;

    // effective window length, clamped
    logic [WL_W-1:0]         w;
    logic [AW-1:0]           eff_pos;
    logic signed [LR_W-1:0]  old;
    logic signed [XSQ_W-1:0] x_ext;
    logic signed [XSQ_W-1:0] old_ext;
    logic [SUM_W-1:0]        mag;
    logic [DIV_W:0]          d_t;
    logic                    d_ge;
    logic [VOL_W+3:0]        s_t;
    logic [VOL_W+3:0]        s_trial;
    logic                    s_ge;
    logic                    in_acc;
    logic                    out_free;

    always_comb begin
        if (r_wl < WL_W'(2)) begin
            w = WL_W'(2);
        end else if (32'(r_wl) > WMAX9) begin
            w = WL_W'(WMAX9);
        end else begin
            w = r_wl;
        end
    end

    assign eff_pos = (32'(r_wpos) >= 32'(w)) ? '0 : r_wpos;
    assign x_ext   = XSQ_W'(r_x);
    assign old_ext = XSQ_W'(old);
    assign mag     = (r_sum < 0) ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // one quotient bit per cycle
    assign d_t  = {r_rem, r_num[NUM_W-1]};
    assign d_ge = d_t >= {1'b0, r_dv};

    // one root bit per cycle
    assign s_t     = {r_srem, r_q[SQR_W-1 -: 2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    assign s_ge    = s_t >= s_trial;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    rv_ram #(
        .WIDTH (LR_W),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (r_pos),
        .i_wdata (r_x),
        .i_raddr (eff_pos),
        .o_rdata (old)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= WL_W'(WL_RESET);
            r_ppy       <= PPY_W'(PPY_RESET);
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_fill      <= '0;
            r_wpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the user must write config only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LEN: begin
                        r_wl    <= i_cfg_data[WL_W-1:0];
                        r_sum   <= '0;
                        r_sumsq <= '0;
                        r_fill  <= '0;
                        r_wpos  <= '0;
                    end
                    CFG_PPY: r_ppy <= i_cfg_data[PPY_W-1:0];
                    default: ;
                endcase
            end

            // a result loaded this cycle keeps the register full
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x     <= $signed(i_log_return);
                        r_pos   <= eff_pos;
                        r_full  <= r_fill >= w;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // stored return is on the read port now
                    r_sum   <= r_sum + SUM_W'(r_x) - (r_full ? SUM_W'(old) : '0);
                    r_xsq   <= XSQ_W'(x_ext * x_ext);
                    r_oldsq <= r_full ? XSQ_W'(old_ext * old_ext) : '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sumsq <= r_sumsq + SQ_W'(r_xsq) - SQ_W'(r_oldsq);
                    r_wpos  <= (32'(r_pos) + 32'd1 >= 32'(w)) ? '0 : r_pos + AW'(1);
                    if (!r_full) begin
                        r_fill <= r_fill + WL_W'(1);
                    end
                    if (r_full || (r_fill + WL_W'(1) >= w)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_res   <= '0;
                        r_resv  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_a     <= PROD_W'(PROD_W'(w) * PROD_W'(r_sumsq));
                    r_b     <= PROD_W'(PROD_W'(mag) * PROD_W'(mag));
                    r_dv    <= DIV_W'(DIV_W'(w) * DIV_W'(w - WL_W'(1)));
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    // negative squared error counts as zero
                    r_a     <= (r_a >= r_b) ? r_a - r_b : '0;
                    r_acc   <= '0;
                    r_pm    <= r_ppy;
                    r_cnt   <= CNT_W'(PPY_W);
                    r_state <= S_PMUL;
                end
                S_PMUL: begin
                    // shift-add, multiplier MSB first
                    r_acc <= {r_acc[ACC_W-2:0], 1'b0}
                           + (r_pm[PPY_W-1] ? ACC_W'(r_a) : '0);
                    r_pm  <= {r_pm[PPY_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_num   <= {r_acc, 8'h00};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_ovf   <= 1'b0;
                    r_cnt   <= CNT_W'(NUM_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= d_ge ? DIV_W'(d_t - {1'b0, r_dv}) : DIV_W'(d_t);
                    r_q   <= {r_q[SQR_W-2:0], d_ge};
                    r_ovf <= r_ovf | r_q[SQR_W-1];
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_SINIT;
                    end
                end
                S_SINIT: begin
                    if (r_ovf) begin
                        r_res   <= '1;
                        r_resv  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_cnt   <= CNT_W'(VOL_W);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= s_ge ? (VOL_W+2)'(s_t - s_trial) : (VOL_W+2)'(s_t);
                    r_root <= {r_root[VOL_W-2:0], s_ge};
                    r_q    <= {r_q[SQR_W-3:0], 2'b00};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res   <= r_root;
                    r_resv  <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_vol       <= r_res;
                        r_volv      <= r_resv;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = r_state != S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_volatility = r_vol;
    assign o_vol_valid  = r_volv;

endmodule

/* src/rv_check.sv */
module rv_check
    import rv_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [LR_W-1:0]       i_log_return,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [VOL_W-1:0]      o_volatility,
    input logic                  o_vol_valid,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // window not yet full gives a zero result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_vol_valid |-> o_volatility == '0)
        else $error("invalid result with nonzero volatility");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after item taken");

    // no result appears in the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result without work time");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_volatility) && $stable(o_vol_valid))
        else $error("stalled result changed");

endmodule

bind rolling_volatility_core rv_check u_rv_check (.*);

/* sim/testbench.sv */
module testbench;
    import rv_pkg::*;

    // Idle-cycle limit for the watchdog. It leaves a wide margin over the
    // slowest item, the longest receiver hold and the longest random gap.
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [VOL_W-1:0] vol;
        logic             full;
    } vol_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [LR_W-1:0]       i_log_return;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [VOL_W-1:0]      o_volatility;
    logic                  o_vol_valid;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rolling_volatility_core i_dut (.*);

    // Predicted results and the mismatch count.
    vol_result_t pending_vols[$];
    int          fails;

    // Predictor state: the window contents and the register copies.
    logic [LR_W-1:0] win_ring[WINDOW_MAX_DEF];
    longint          win_sum;
    logic [63:0]     win_sumsq;
    int              win_fill;
    int              win_pos;
    int              wlen_reg;
    int              ppy_reg;

    // Receiver-side controls.
    bit  quiet_mode;    // no random stalls and no gaps
    int  hold_reqs;     // long hold-offs asked for by the tests
    int  hold_taken;    // long hold-offs started by the receiver
    int  idle_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void clear_window();
        foreach (win_ring[k]) win_ring[k] = '0;
        win_sum   = 0;
        win_sumsq = '0;
        win_fill  = 0;
        win_pos   = 0;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Advance the window by one return and work out the volatility result.
    function automatic vol_result_t next_volatility(logic [LR_W-1:0] ret);
        vol_result_t  r;
        int           w;
        int           p;
        longint       x;
        longint       old;
        logic [63:0]  mag;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] num;
        w = wlen_reg < 2 ? 2 : (wlen_reg > WINDOW_MAX_DEF ? WINDOW_MAX_DEF : wlen_reg);
        x = longint'($signed(ret));
        p = win_pos >= w ? 0 : win_pos;
        if (win_fill >= w) begin
            old = longint'($signed(win_ring[p]));
            win_sum   = win_sum - old;
            win_sumsq = win_sumsq - 64'(old * old);
        end else begin
            win_fill++;
        end
        win_sum   = win_sum + x;
        win_sumsq = win_sumsq + 64'(x * x);
        win_ring[p] = ret;
        p++;
        win_pos = p >= w ? 0 : p;
        if (win_fill < w) begin
            r.vol  = '0;
            r.full = 1'b0;
            return r;
        end
        mag = win_sum < 0 ? 64'(-win_sum) : 64'(win_sum);
        a   = 128'(w) * 128'(win_sumsq);
        b   = 128'(mag) * 128'(mag);
        num = a < b ? 128'd0 : a - b;
        num = num * 128'(ppy_reg * 256);
        num = num / 128'(w * (w - 1));
        r.vol  = num[127:64] != 0 ? '1 : VOL_W'(floor_sqrt(num[63:0]));
        r.full = 1'b1;
        return r;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        fails++;
    endtask

    // Gap length: mostly short, sometimes long.
    function automatic int pick_gap();
        if (quiet_mode) return 0;
        if ($urandom_range(0, 1) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Offer one return and wait for it to be taken.
    task automatic send_return(logic [LR_W-1:0] ret);
        int          gap;
        vol_result_t want;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_log_return <= ret;
        do @(posedge i_clk); while (o_in_stall);
        want = next_volatility(ret);
        pending_vols.insert(pending_vols.size(), want);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_vols.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_LEN) begin
            wlen_reg = value & 'h1FF;
            clear_window();
        end else if (idx == CFG_PPY) begin
            ppy_reg = value & 'h7FF;
        end
    endtask

    // Return value: full range, typical small values, or extremes.
    function automatic logic [LR_W-1:0] rand_return();
        case ($urandom_range(0, 5))
            0, 1: return LR_W'($urandom);
            2:    return LR_W'($signed($urandom_range(0, 40000)) - 20000);
            3:    return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            default: return LR_W'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // ---------------- receiver and checker ----------------
    int stall_left;
    int hold_left;
    always @(posedge i_clk) begin
        vol_result_t want;
        if (o_out_valid && !i_out_stall) begin
            if (pending_vols.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = pending_vols.pop_front();
                if (o_vol_valid !== want.full)
                    report($sformatf("vol_valid %b want %b", o_vol_valid, want.full));
                if (o_volatility !== want.vol)
                    report($sformatf("volatility %h want %h", o_volatility, want.vol));
            end
        end
        if (hold_taken != hold_reqs && hold_left == 0) begin
            hold_taken = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_out_stall <= stall_left > 0;
            if (stall_left > 0) stall_left--;
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // Reset values: window 20, annualization 252.
    task automatic test_reset_defaults();
        repeat (25) send_return(rand_return());
    endtask

    // Field extremes and saturation on the smallest window.
    task automatic test_extremes();
        write_reg(CFG_WINDOW_LEN, 2);
        write_reg(CFG_PPY, 2047);
        send_return(24'h7FFFFF);
        send_return(24'h800000);   // spread saturates
        send_return(24'h7FFFFF);
        send_return(24'h000000);
        send_return(24'h000000);   // zero spread
        send_return(24'hFFFFFF);
        write_reg(CFG_PPY, 0);      // zero annualization gives zero
        send_return(24'h123456);
        send_return(24'hEDCBA9);
        write_reg(CFG_PPY, 1);
        send_return(24'h000001);
        send_return(24'h800000);
    endtask

    // Window lengths below and above the legal range clamp.
    task automatic test_window_clamp();
        int lens[4] = '{0, 1, 257, 511};
        foreach (lens[k]) begin
            write_reg(CFG_WINDOW_LEN, lens[k]);
            write_reg(CFG_PPY, $urandom_range(1, 1024));
            repeat (3) send_return(rand_return());
        end
        write_reg(CFG_WINDOW_LEN, 511);
        repeat (260) send_return(rand_return());
    endtask

    // Writes to unused indexes are ignored; annualization change keeps window.
    task automatic test_reg_writes();
        write_reg(CFG_WINDOW_LEN, 4);
        write_reg(CFG_PPY, 252);
        repeat (5) send_return(rand_return());
        write_reg(CFG_SPARE_A, 2047);
        write_reg(CFG_SPARE_B, 0);
        send_return(rand_return());
        write_reg(CFG_PPY, 1024);
        repeat (3) send_return(rand_return());
    endtask

    // Long receiver hold with the sender still offering, then a full pause.
    task automatic test_backpressure();
        write_reg(CFG_WINDOW_LEN, 3);
        hold_reqs++;
        quiet_mode = 1'b1;
        repeat (12) send_return(rand_return());
        quiet_mode = 1'b0;
        drain();
        repeat (10) send_return(rand_return());
    endtask

    // Random phases over many window and annualization settings.
    task automatic test_random();
        int n;
        int wl;
        for (int ph = 0; ph < 26; ph++) begin
            wl = ph == 7 ? 256 : ($urandom_range(0, 3) == 0 ? $urandom_range(2, 64)
                                                           : $urandom_range(2, 12));
            write_reg(CFG_WINDOW_LEN, wl);
            write_reg(CFG_PPY, ph == 3 ? 1024 : $urandom_range(0, 2047));
            quiet_mode = ph % 5 == 4;
            n = wl + $urandom_range(10, 40);
            repeat (n) send_return(rand_return());
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        quiet_mode = 1'b0;
        hold_reqs = 0;
        wlen_reg = WL_RESET;
        ppy_reg = PPY_RESET;
        clear_window();
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_log_return <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_WINDOW_LEN;
        i_cfg_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_reg_writes();
        test_backpressure();
        test_window_clamp();
        test_random();

        drain();
        repeat (200) @(posedge i_clk);
        if (fails == 0 && pending_vols.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
